@@ hdl/mm4_pkg.sv @@
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// No dependencies; imported by every module of the block but mm4_ram.
package mm4_pkg;

    localparam int INDEX_W     = 4;   // column-major element index
    localparam int VALUE_W     = 32;  // element and product field width on the ports
    localparam int REQ_W       = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [REQ_W-1:0] REQ_LOAD_LEFT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_RIGHT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MULTIPLY   = 2'd2;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 4'd15;

    typedef enum logic [1:0]
    {
        KIND_LOAD_LEFT,
        KIND_LOAD_RIGHT,
        KIND_MULTIPLY
    } kind_t;

    typedef struct packed
    {
        kind_t               kind;
        logic [INDEX_W-1:0]  index;
        logic [VALUE_W-1:0]  value;
    } item_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_ISSUE,
        BK_WAIT
    } back_state_t;

endpackage

@@ hdl/mm4_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the left and right matrix stores.
module mm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/mm4_front.sv @@
// Front end: accepts request words, classifies them and queues them for the back end.
// Depends on mm4_pkg.
module mm4_front
    import mm4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [INDEX_W-1:0] element_index,
    input  logic [VALUE_W-1:0] element_value,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    item_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    item_t classified;
    logic  keep;
    logic  push;

    always_comb
    begin
        classified.index = element_index;
        classified.value = element_value;
        classified.kind  = KIND_MULTIPLY;
        keep             = 1'b1;
        unique case (req_type)
            REQ_LOAD_LEFT:  classified.kind = KIND_LOAD_LEFT;
            REQ_LOAD_RIGHT: classified.kind = KIND_LOAD_RIGHT;
            REQ_MULTIPLY:   classified.kind = KIND_MULTIPLY;
            default:        keep = 1'b0;   // unused code: taken and dropped
        endcase
    end

    assign s_tready = (count_reg != CNT_FULL);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

@@ hdl/mm4_back.sv @@
// Back end: matrix stores, multiply-accumulate sequencer, scaling, saturation
// and output register. Depends on mm4_pkg and mm4_ram.
module mm4_back
    import mm4_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [INDEX_W-1:0] product_index,
    output logic [VALUE_W-1:0] product_value,
    output logic               last_of_run
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int PW = 2 * EW;      // one exact product
    localparam int AW = 2 * EW + 2;  // exact sum of four products

    localparam logic signed [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};

    back_state_t state_reg, state_next;
    logic [INDEX_W-1:0] elem_reg, elem_next;
    logic [1:0]         k_reg, k_next;

    logic rd_issue;
    logic wr_left, wr_right;

    logic [EW-1:0] left_q, right_q;
    logic [3:0]    left_addr, right_addr;

    logic rd_v_reg, rd_first_reg, rd_last_reg;
    logic prod_v_reg, prod_first_reg, prod_last_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic done_reg;
    logic load_out;

    logic signed [AW-1:0] shifted;
    logic signed [EW-1:0] saturated;
    logic                 fits;

    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic signed [EW-1:0] out_value_reg;
    logic                 out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        k_next     = k_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && (q_item.kind == KIND_MULTIPLY))
                begin
                    state_next = BK_ISSUE;
                    elem_next  = '0;
                    k_next     = '0;
                end
            end
            BK_ISSUE:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                if (load_out)
                begin
                    if (elem_reg == LAST_INDEX)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_ISSUE;
                        elem_next  = elem_reg + 1'b1;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop    = 1'b0;
        rd_issue = 1'b0;
        wr_left  = 1'b0;
        wr_right = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop    = q_valid;
                wr_left  = q_valid && (q_item.kind == KIND_LOAD_LEFT);
                wr_right = q_valid && (q_item.kind == KIND_LOAD_RIGHT);
            end
            BK_ISSUE: rd_issue = 1'b1;
            BK_WAIT:  rd_issue = 1'b0;
            default:  rd_issue = 1'b0;
        endcase
    end

    // left(k,row) at k*4+row, right(col,k) at col*4+k
    assign left_addr  = {k_reg, elem_reg[1:0]};
    assign right_addr = {elem_reg[3:2], k_reg};

    mm4_ram #(.WIDTH(EW), .DEPTH(16)) u_left_ram
    (
        .clk     (clk),
        .wr_en   (wr_left),
        .wr_addr (q_item.index),
        .wr_data (q_item.value[EW-1:0]),
        .rd_addr (left_addr),
        .rd_data (left_q)
    );

    mm4_ram #(.WIDTH(EW), .DEPTH(16)) u_right_ram
    (
        .clk     (clk),
        .wr_en   (wr_right),
        .wr_addr (q_item.index),
        .wr_data (q_item.value[EW-1:0]),
        .rd_addr (right_addr),
        .rd_data (right_q)
    );

    // Floor shift, then saturate when the upper bits are not a pure sign extension
    always_comb
    begin
        shifted   = acc_reg >>> FRACTION_BITS;
        fits      = (shifted[AW-1:EW-1] == '0) || (shifted[AW-1:EW-1] == '1);
        saturated = fits ? shifted[EW-1:0] : (shifted[AW-1] ? SAT_MIN : SAT_MAX);
    end

    assign load_out = done_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            elem_reg      <= '0;
            k_reg         <= '0;
            rd_v_reg      <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            elem_reg       <= elem_next;
            k_reg          <= k_next;
            rd_v_reg       <= rd_issue;
            rd_first_reg   <= rd_issue && (k_reg == 2'd0);
            rd_last_reg    <= rd_issue && (k_reg == 2'd3);
            prod_v_reg     <= rd_v_reg;
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;
            if (prod_v_reg && prod_last_reg)
            begin
                done_reg <= 1'b1;
            end
            else if (load_out)
            begin
                done_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= $signed(left_q) * $signed(right_q);
        end
        if (prod_v_reg)
        begin
            acc_reg <= (prod_first_reg ? AW'(0) : acc_reg) + AW'(prod_reg);
        end
        if (load_out)
        begin
            out_index_reg <= elem_reg;
            out_value_reg <= saturated;
            out_last_reg  <= (elem_reg == LAST_INDEX);
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign product_index = out_index_reg;
    assign product_value = VALUE_W'(out_value_reg);
    assign last_of_run   = out_last_reg;

endmodule

@@ hdl/matrix4_multiply.sv @@
// Top level of the 4x4 signed fixed-point matrix multiplier.
// Depends on mm4_pkg, mm4_front and mm4_back.

// Load words (tuser 0 left, 1 right) write one column-major element of a matrix and
// produce nothing; code 3 is taken and dropped. A multiply word (tuser 2) yields 16 words,
// element index 0..15 in order, tlast on the last, each the floor-scaled and saturated sum
// over k of left(k,row)*right(col,k). Words pass a 4-deep queue; the back end takes one
// load per cycle while idle, not while a multiply runs. In a multiply, one shared multiplier
// fed by one read port on each matrix RAM does four products per element, through the
// read, multiply and accumulate pipeline. Elements must be written before they are used.
module matrix4_multiply
    import mm4_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // element_index[3:0], element_value[35:4], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // product_index[3:0], product_value[35:4], zero pad
    output logic        m_tlast
);

    logic               q_valid;
    item_t              q_item;
    logic               q_pop;
    logic [INDEX_W-1:0] product_index;
    logic [VALUE_W-1:0] product_value;

    mm4_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser),
        .element_index (s_tdata[3:0]),
        .element_value (s_tdata[35:4]),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    mm4_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .product_index (product_index),
        .product_value (product_value),
        .last_of_run   (m_tlast)
    );

    assign m_tdata = {4'b0, product_value, product_index};

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for matrix4_multiply: loads and multiplies on the input stream,
// every product word checked against an in-bench fixed-point matrix product.
// Depends on mm4_pkg and the matrix4_multiply RTL.
module tb_top;
    import mm4_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W = 32;
    localparam int IDLE_LIMIT = 4000;    // cycles with no word moving on either side
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_ITEMS = 290;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct
    {
        logic [REQ_W-1:0]   req;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        bit                 drain;    // hold until every product has come back
    } request_t;

    typedef struct
    {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } product_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // element_index[3:0], element_value[35:4], zero pad
    logic [1:0]  s_tuser = '0;    // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // product_index[3:0], product_value[35:4], zero pad
    logic        m_tlast;

    request_t pending_requests[$];
    product_t expected_products[$];
    request_t current_req;

    logic signed [ELEM_W-1:0] left_elems [16];
    logic signed [ELEM_W-1:0] right_elems [16];

    int unsigned in_gap = 0;
    int unsigned in_calm = 0;
    int unsigned out_stall = 0;
    int unsigned out_calm = 0;
    int unsigned idle_cycles = 0;
    int          accepted_count = 0;
    int          total_requests = 0;
    int          errors = 0;

    matrix4_multiply #(
        .FRACTION_BITS(FRAC_BITS),
        .ELEMENT_WIDTH(ELEM_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return '0;
            4: return 32'h0001_0000;     // +1.0
            5: return 32'hFFFF_0000;     // -1.0
            default: return $urandom_range(32'h7_FFFF) - 32'h4_0000;    // within +-4.0
        endcase
    endfunction

    function automatic void queue_request(logic [REQ_W-1:0] req, logic [INDEX_W-1:0] index,
                                          logic [VALUE_W-1:0] value, bit drain);
        request_t r;
        r.req = req;
        r.index = index;
        r.value = value;
        r.drain = drain;
        pending_requests.push_back(r);
    endfunction

    // all 16 elements of left x right, floor-scaled and saturated
    function automatic void push_matrix_product();
        logic signed [67:0] acc;
        logic signed [67:0] scaled;
        product_t p;
        for (int n = 0; n < 16; n++)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
                acc = acc + left_elems[k * 4 + (n & 3)] * right_elems[(n >> 2) * 4 + k];
            scaled = acc >>> FRAC_BITS;
            if (scaled > 68'sh7FFF_FFFF)
                p.value = 32'h7FFF_FFFF;
            else if (scaled < -68'sh8000_0000)
                p.value = 32'h8000_0000;
            else
                p.value = scaled[31:0];
            p.index = INDEX_W'(n);
            p.last = (n == 15);
            expected_products.push_back(p);
        end
    endfunction

    function automatic void record_request(request_t r);
        case (r.req)
            REQ_LOAD_LEFT:  left_elems[r.index] = r.value;
            REQ_LOAD_RIGHT: right_elems[r.index] = r.value;
            REQ_MULTIPLY:   push_matrix_product();
            default:        ;
        endcase
    endfunction

    function automatic void check_product();
        product_t want;
        if (expected_products.size() == 0)
        begin
            $error("unexpected product word: index %0d value %0d",
                   m_tdata[3:0], $signed(m_tdata[35:4]));
            errors++;
        end
        else
        begin
            want = expected_products.pop_front();
            if (m_tdata[3:0] !== want.index)
            begin
                $error("product_index: expected %0d, got %0d", want.index, m_tdata[3:0]);
                errors++;
            end
            if (m_tdata[35:4] !== want.value)
            begin
                $error("product_value: expected %0d, got %0d",
                       $signed(want.value), $signed(m_tdata[35:4]));
                errors++;
            end
            if (m_tlast !== want.last)
            begin
                $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                errors++;
            end
        end
    endfunction

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            in_gap <= 0;
            in_calm <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                record_request(current_req);
                accepted_count <= accepted_count + 1;
            end
            if (in_calm != 0)
                in_calm <= in_calm - 1;
            else if ($urandom_range(150) == 0)
                in_calm <= 250;
            if (!s_tvalid || s_tready)
            begin
                if (in_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain && expected_products.size() != 0))
                begin
                    current_req = pending_requests.pop_front();
                    s_tdata <= {4'b0, current_req.value, current_req.index};
                    s_tuser <= current_req.req;
                    s_tvalid <= 1'b1;
                    in_gap <= (in_calm != 0) ? 0 : pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: check each word taken, then decide on the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_stall <= 0;
            out_calm <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_product();
            if (out_calm != 0)
                out_calm <= out_calm - 1;
            else if ($urandom_range(150) == 0)
                out_calm <= 250;
            if (out_stall != 0)
            begin
                m_tready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                out_stall <= (out_calm != 0) ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAIL matrix4_multiply");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int made;
        // both matrices to identity; every entry is written before any multiply
        for (int i = 0; i < 16; i++)
        begin
            queue_request(REQ_LOAD_LEFT, INDEX_W'(i), (i % 5 == 0) ? 32'h0001_0000 : '0, 1'b0);
            queue_request(REQ_LOAD_RIGHT, INDEX_W'(i), (i % 5 == 0) ? 32'h0001_0000 : '0, 1'b0);
        end
        queue_request(REQ_MULTIPLY, '0, '0, 1'b0);
        // row 0 of left and column 0 of right at the positive bound, column 1 at the negative
        for (int k = 0; k < 4; k++)
        begin
            queue_request(REQ_LOAD_LEFT, INDEX_W'(k * 4), 32'h7FFF_FFFF, 1'b0);
            queue_request(REQ_LOAD_RIGHT, INDEX_W'(k), 32'h7FFF_FFFF, 1'b0);
            queue_request(REQ_LOAD_RIGHT, INDEX_W'(4 + k), 32'h8000_0000, 1'b0);
        end
        // multiply ignores index and value
        queue_request(REQ_MULTIPLY, 4'hF, 32'hFFFF_FFFF, 1'b0);
        // -1 lsb times +1 lsb must floor to -1 lsb, not truncate to zero
        queue_request(REQ_LOAD_LEFT, 4'd5, 32'hFFFF_FFFF, 1'b0);
        queue_request(REQ_LOAD_RIGHT, 4'd5, 32'h0000_0001, 1'b0);
        // unused code is dropped, and this word waits until the run has drained
        queue_request(REQ_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1);
        // most negative squared: far past the positive bound
        queue_request(REQ_LOAD_LEFT, 4'd15, 32'h8000_0000, 1'b0);
        queue_request(REQ_LOAD_RIGHT, 4'd15, 32'h8000_0000, 1'b0);
        queue_request(REQ_MULTIPLY, 4'h0, 32'h0000_0000, 1'b0);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            if ($urandom_range(19) == 0)
                queue_request(REQ_UNUSED, INDEX_W'($urandom_range(15)), $urandom(), 1'b0);
            else if ($urandom_range(3) == 0)
            begin
                queue_request(REQ_MULTIPLY, INDEX_W'($urandom_range(15)), $urandom(),
                              (made == RANDOM_ITEMS / 2) || ($urandom_range(99) == 0));
                made++;
            end
            else
            begin
                queue_request($urandom_range(1) ? REQ_LOAD_RIGHT : REQ_LOAD_LEFT,
                              INDEX_W'($urandom_range(15)), pick_value(),
                              made == RANDOM_ITEMS / 2);
                made++;
            end
        end
        total_requests = pending_requests.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_requests)
            @(posedge clk);
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS matrix4_multiply");
        else
            $display("FAIL matrix4_multiply");
        $finish;
    end

endmodule
